// ----- sv/bief_pkg.sv -----
// Shared types, codes and the control program of the binary image edge follower.
// Used by the sequencer, the pixel store wrapper logic and the top level.
package bief_pkg;

    typedef logic [3:0] pc_t;
    typedef logic [1:0] side_t;
    typedef logic [9:0] coord_t;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    localparam side_t SIDE_UP    = 2'd0;
    localparam side_t SIDE_RIGHT = 2'd1;
    localparam side_t SIDE_DOWN  = 2'd2;
    localparam side_t SIDE_LEFT  = 2'd3;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [1:0] RD_P = 2'd0;
    localparam logic [1:0] RD_N = 2'd1;
    localparam logic [1:0] RD_T = 2'd2;
    localparam logic [1:0] RD_S = 2'd3;

    localparam logic [3:0] ACT_NONE    = 4'd0;
    localparam logic [3:0] ACT_CLEAR   = 4'd1;
    localparam logic [3:0] ACT_IDLE    = 4'd2;
    localparam logic [3:0] ACT_WRITE   = 4'd3;
    localparam logic [3:0] ACT_START   = 4'd4;
    localparam logic [3:0] ACT_LATCH_P = 4'd5;
    localparam logic [3:0] ACT_EVAL    = 4'd6;
    localparam logic [3:0] ACT_DEC     = 4'd7;
    localparam logic [3:0] ACT_LATCH_T = 4'd8;
    localparam logic [3:0] ACT_MOVE    = 4'd9;
    localparam logic [3:0] ACT_OUT     = 4'd10;

    localparam logic [2:0] NX_NEXT     = 3'd0;
    localparam logic [2:0] NX_JUMP     = 3'd1;
    localparam logic [2:0] NX_IF_MORE  = 3'd2;
    localparam logic [2:0] NX_IF_DONE  = 3'd3;
    localparam logic [2:0] NX_DISPATCH = 3'd4;

    localparam pc_t PC_CLR   = 4'd0;
    localparam pc_t PC_IDLE  = 4'd1;
    localparam pc_t PC_WR    = 4'd2;
    localparam pc_t PC_ST    = 4'd3;
    localparam pc_t PC_V0    = 4'd4;
    localparam pc_t PC_V1    = 4'd5;
    localparam pc_t PC_EVAL  = 4'd6;
    localparam pc_t PC_T0    = 4'd7;
    localparam pc_t PC_T1    = 4'd8;
    localparam pc_t PC_T2    = 4'd9;
    localparam pc_t PC_OUT   = 4'd10;

    typedef struct packed {
        logic [1:0] rd_sel;
        logic [3:0] act;
        logic [2:0] nx;
        pc_t        target;
    } ucode_t;

    typedef struct packed {
        logic       in_acc;
        logic       out_free;
        logic       clr_last;
        logic       more;
        logic [1:0] op;
    } seq_stat_t;

    function automatic ucode_t ucode_rom(input pc_t pc);
        ucode_t w;
        w = '{rd_sel: RD_P, act: ACT_NONE, nx: NX_JUMP, target: PC_IDLE};
        unique case (pc)
            PC_CLR:  w = '{rd_sel: RD_P, act: ACT_CLEAR,   nx: NX_NEXT,     target: PC_IDLE};
            PC_IDLE: w = '{rd_sel: RD_P, act: ACT_IDLE,    nx: NX_DISPATCH, target: PC_IDLE};
            PC_WR:   w = '{rd_sel: RD_P, act: ACT_WRITE,   nx: NX_JUMP,     target: PC_V0};
            PC_ST:   w = '{rd_sel: RD_P, act: ACT_START,   nx: NX_JUMP,     target: PC_V0};
            PC_V0:   w = '{rd_sel: RD_P, act: ACT_NONE,    nx: NX_NEXT,     target: PC_IDLE};
            PC_V1:   w = '{rd_sel: RD_N, act: ACT_LATCH_P, nx: NX_NEXT,     target: PC_IDLE};
            PC_EVAL: w = '{rd_sel: RD_P, act: ACT_EVAL,    nx: NX_IF_DONE,  target: PC_OUT};
            PC_T0:   w = '{rd_sel: RD_T, act: ACT_DEC,     nx: NX_NEXT,     target: PC_IDLE};
            PC_T1:   w = '{rd_sel: RD_S, act: ACT_LATCH_T, nx: NX_NEXT,     target: PC_IDLE};
            PC_T2:   w = '{rd_sel: RD_P, act: ACT_MOVE,    nx: NX_IF_MORE,  target: PC_T0};
            PC_OUT:  w = '{rd_sel: RD_P, act: ACT_OUT,     nx: NX_JUMP,     target: PC_IDLE};
            default: w = '{rd_sel: RD_P, act: ACT_NONE,    nx: NX_JUMP,     target: PC_IDLE};
        endcase
        return w;
    endfunction

    function automatic coord_t delta_x(input side_t s);
        coord_t d;
        d = '0;
        unique case (s)
            SIDE_RIGHT: d = 10'd1;
            SIDE_LEFT:  d = 10'h3FF;
            default:    d = '0;
        endcase
        return d;
    endfunction

    function automatic coord_t delta_y(input side_t s);
        coord_t d;
        d = '0;
        unique case (s)
            SIDE_UP:   d = 10'h3FF;
            SIDE_DOWN: d = 10'd1;
            default:   d = '0;
        endcase
        return d;
    endfunction

endpackage

// ----- sv/binary_image_edge_follower.sv -----
// Top level of the binary image edge follower; uses bief_pkg, bief_useq and bief_store.
// A write or a start passes through its write or start step, the validity reads and the
// evaluation to the output register; an unused op or a step item passes through the validity
// reads, the evaluation, the states T0, T1 and T2 for each single step taken, then the output.
// One item at a time, taken only after the output step, which waits while a result waits for
// m_tready; a single step makes two store reads; s_tready is low until the reset clear ends.
module binary_image_edge_follower import bief_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // x, y, pixel, side, counter_clockwise, steps, zero pad
    input  logic [1:0]  s_tuser,  // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // cur_x, cur_y, cur_side, valid_res, at_start, zero pad
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;

    ucode_t    ctrl;
    seq_stat_t stat;

    logic [8:0]  img_w_reg;
    logic [8:0]  img_h_reg;
    logic [8:0]  lim_w;
    logic [8:0]  lim_h;

    logic [1:0]  op_reg;
    logic [7:0]  x_reg;
    logic [7:0]  y_reg;
    logic        pixel_reg;
    side_t       side_reg;
    logic        ccw_reg;
    logic [7:0]  cnt_reg;

    logic [7:0]  cur_x_reg;
    logic [7:0]  cur_y_reg;
    side_t       cur_side_reg;
    logic [7:0]  start_x_reg;
    logic [7:0]  start_y_reg;
    side_t       start_side_reg;

    logic        vp_reg;
    logic        valid_reg;
    logic        t_reg;
    logic        inr_reg;
    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;

    logic        in_acc;
    logic        out_free;
    logic        rd_bit;
    logic        bit_now;
    logic        valid_now;
    logic        vsrc;
    logic        at_start;
    side_t       fwd;
    side_t       back;
    coord_t      p_x;
    coord_t      p_y;
    coord_t      n_x;
    coord_t      n_y;
    coord_t      s_x;
    coord_t      s_y;
    coord_t      t_x;
    coord_t      t_y;
    coord_t      r_x;
    coord_t      r_y;
    logic        r_inr;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign cfg_ready = 1'b1;
    assign s_tready  = (ctrl.act == ACT_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign lim_w = (int'(img_w_reg) < MAX_WIDTH)  ? img_w_reg : 9'(MAX_WIDTH);
    assign lim_h = (int'(img_h_reg) < MAX_HEIGHT) ? img_h_reg : 9'(MAX_HEIGHT);

    assign fwd  = ccw_reg ? side_t'(cur_side_reg - 2'd1) : side_t'(cur_side_reg + 2'd1);
    assign back = ccw_reg ? side_t'(cur_side_reg + 2'd1) : side_t'(cur_side_reg - 2'd1);
    assign p_x  = {2'b00, cur_x_reg};
    assign p_y  = {2'b00, cur_y_reg};
    assign n_x  = p_x + delta_x(cur_side_reg);
    assign n_y  = p_y + delta_y(cur_side_reg);
    assign s_x  = p_x + delta_x(fwd);
    assign s_y  = p_y + delta_y(fwd);
    assign t_x  = s_x + delta_x(cur_side_reg);
    assign t_y  = s_y + delta_y(cur_side_reg);

    always_comb
    begin
        unique case (ctrl.rd_sel)
            RD_P:
            begin
                r_x = p_x;
                r_y = p_y;
            end
            RD_N:
            begin
                r_x = n_x;
                r_y = n_y;
            end
            RD_T:
            begin
                r_x = t_x;
                r_y = t_y;
            end
            RD_S:
            begin
                r_x = s_x;
                r_y = s_y;
            end
        endcase
    end

    assign r_inr   = !r_x[9] && !r_y[9] && (r_x[8:0] < lim_w) && (r_y[8:0] < lim_h);
    assign rd_addr = {YW'(r_y), XW'(r_x)};
    assign wr_addr = {YW'(y_reg), XW'(x_reg)};
    assign wr_en   = (ctrl.act == ACT_WRITE) && (int'(x_reg) < MAX_WIDTH) &&
                     (int'(y_reg) < MAX_HEIGHT);

    assign bit_now   = rd_bit && inr_reg;
    assign valid_now = vp_reg && !bit_now;
    assign vsrc      = (ctrl.act == ACT_EVAL) ? valid_now : valid_reg;
    assign at_start  = (cur_x_reg == start_x_reg) && (cur_y_reg == start_y_reg) &&
                       (cur_side_reg == start_side_reg);

    assign stat.in_acc   = in_acc;
    assign stat.out_free = out_free;
    assign stat.more     = (op_reg == OP_STEP) && (cnt_reg != 8'd0) && vsrc;
    assign stat.op       = s_tuser;

    bief_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    bief_store #(
        .AW (AW)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr_en   (ctrl.act == ACT_CLEAR),
        .clr_last (stat.clr_last),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (pixel_reg),
        .rd_addr  (rd_addr),
        .rd_data  (rd_bit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg <= 9'd256;
            img_h_reg <= 9'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  img_w_reg <= cfg_data;
                REG_IMAGE_HEIGHT: img_h_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg    <= s_tuser;
            x_reg     <= s_tdata[7:0];
            y_reg     <= s_tdata[15:8];
            pixel_reg <= s_tdata[16];
            side_reg  <= s_tdata[18:17];
            ccw_reg   <= s_tdata[19];
            cnt_reg   <= s_tdata[27:20];
        end
        else if (ctrl.act == ACT_DEC)
        begin
            cnt_reg <= cnt_reg - 8'd1;
        end
        if (ctrl.act == ACT_LATCH_P)
        begin
            vp_reg <= bit_now;
        end
        if (ctrl.act == ACT_LATCH_T)
        begin
            t_reg <= bit_now;
        end
        if (ctrl.act == ACT_OUT && out_free)
        begin
            m_tdata_reg <= {4'b0000, at_start, valid_reg, cur_side_reg, cur_y_reg, cur_x_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            cur_side_reg   <= SIDE_UP;
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            start_side_reg <= SIDE_UP;
            valid_reg      <= 1'b0;
            inr_reg        <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            inr_reg <= r_inr;
            if (ctrl.act == ACT_START)
            begin
                cur_x_reg      <= x_reg;
                cur_y_reg      <= y_reg;
                cur_side_reg   <= side_reg;
                start_x_reg    <= x_reg;
                start_y_reg    <= y_reg;
                start_side_reg <= side_reg;
            end
            else if (ctrl.act == ACT_MOVE)
            begin
                priority if (t_reg)
                begin
                    cur_x_reg    <= t_x[7:0];
                    cur_y_reg    <= t_y[7:0];
                    cur_side_reg <= back;
                end
                else if (bit_now)
                begin
                    cur_x_reg <= s_x[7:0];
                    cur_y_reg <= s_y[7:0];
                end
                else
                begin
                    cur_side_reg <= fwd;
                end
            end
            if (ctrl.act == ACT_EVAL)
            begin
                valid_reg <= valid_now;
            end
            if (ctrl.act == ACT_OUT && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // A single step is only ever taken from an element found valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.act == ACT_MOVE) |-> valid_reg)
        else $error("step taken from an invalid edge element");

    // A result appears only out of the output step of the program.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(ctrl.act == ACT_OUT))
        else $error("result beat raised outside the output step");

    // The step count never wraps below zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.act == ACT_DEC) |-> (cnt_reg != 8'd0))
        else $error("step counter decremented at zero");

endmodule

// ----- sv/bief_store.sv -----
// One-bit pixel store with one write port, one registered read port and a clearing pass.
// Depends on nothing but its address width parameter.
module bief_store #(
    parameter int AW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clr_en,
    output logic          clr_last,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic          wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic          rd_data
);

    logic          mem [1 << AW];
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] clr_addr_next;
    logic          rd_data_reg;

    assign clr_last      = &clr_addr_reg;
    assign clr_addr_next = clr_addr_reg + AW'(1);
    assign rd_data       = rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (clr_en)
        begin
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_en)
        begin
            mem[clr_addr_reg] <= 1'b0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

// ----- sv/bief_useq.sv -----
// Program counter and control program sequencer of the edge follower.
// Uses bief_pkg for the control word layout and the program table.
module bief_useq import bief_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  seq_stat_t stat,
    output ucode_t    ctrl
);

    pc_t  pc_reg;
    pc_t  pc_next;
    pc_t  pc_inc;
    logic hold;

    assign ctrl   = ucode_rom(pc_reg);
    assign pc_inc = pc_reg + 4'd1;
    assign hold   = (ctrl.act == ACT_IDLE  && !stat.in_acc)   ||
                    (ctrl.act == ACT_OUT   && !stat.out_free) ||
                    (ctrl.act == ACT_CLEAR && !stat.clr_last);

    always_comb
    begin
        pc_next = pc_reg;
        if (!hold)
        begin
            unique case (ctrl.nx)
                NX_NEXT:    pc_next = pc_inc;
                NX_JUMP:    pc_next = ctrl.target;
                NX_IF_MORE: pc_next = stat.more ? ctrl.target : pc_inc;
                NX_IF_DONE: pc_next = stat.more ? pc_inc : ctrl.target;
                NX_DISPATCH:
                begin
                    priority if (stat.op == OP_WRITE)
                        pc_next = PC_WR;
                    else if (stat.op == OP_START)
                        pc_next = PC_ST;
                    else
                        pc_next = PC_V0;
                end
                default:    pc_next = PC_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_CLR;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule
